[rtl/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

[rtl/brs_pkg.sv]
package brs_pkg;
    localparam logic [1:0] ACT_LOAD_LOWER = 2'd0;
    localparam logic [1:0] ACT_LOAD_UPPER = 2'd1;
    localparam logic [1:0] ACT_VALUE      = 2'd2;
    localparam logic [30:0] ERR_MAX = 31'h7FFF_FFFF;
    localparam logic [0:0] REG_TOL   = 1'b0;
    localparam logic [0:0] REG_LIMIT = 1'b1;
    localparam logic       KIND_REQUEST = 1'b0;
    localparam logic       KIND_DONE    = 1'b1;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;   // magnitude
        logic [32:0] divisor;    // magnitude, nonzero
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;
endpackage

[rtl/brs_divider.sv]
// Unsigned restoring divider, one quotient bit per cycle.
module brs_divider import brs_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [63:0] quo_reg, quo_next;
    logic [33:0] rem_reg, rem_next;
    logic [32:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] shifted;
    logic [34:0] trial;

    always_comb begin
        shifted   = {rem_reg[32:0], quo_reg[63]};
        trial     = {1'b0, shifted} - {2'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial[34]) begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end else begin
                rem_next = trial[33:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule

[rtl/bracketed_root_solver.sv]
// False-position root finder, Q16.16. Load the lower point (action 0), then the
// upper point (action 1); each later action 2 item carries f at the requested
// abscissa. Every item is answered with at most one result: a request for the
// next point, or a done result with root, iteration count and error. An action 1
// item runs at most one pass of the shared bit-serial divider (the next point) and
// an action 2 item at most two (relative error, then the next point). s_ready is
// low while an item is in work or its result waits.
`include "assert_macros.svh"
module bracketed_root_solver import brs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_action,
    input  logic signed [31:0] s_point,
    input  logic signed [31:0] s_function_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_kind,
    output logic signed [31:0] m_abscissa,
    output logic [15:0]        m_iterations,
    output logic [30:0]        m_error_measure,
    output logic               m_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_ERR_MUL, ST_ERR_WAIT, ST_ADV, ST_MUL, ST_DIV_START,
        ST_DIV_WAIT, ST_OUT
    } state_t;

    state_t state_reg;
    logic [30:0] tol_reg;
    logic [15:0] limit_reg;
    logic signed [31:0] lp_reg, up_reg, lv_reg, uv_reg, est_reg, pend_reg;
    logic [15:0] iter_reg;
    logic        solving_reg;
    logic signed [31:0] xi_reg, newx_reg;
    logic [30:0] err_reg;
    logic        qneg_reg;
    logic signed [32:0] dx_reg;
    logic signed [32:0] df_reg;
    logic signed [64:0] prod_reg;
    logic [63:0] dividend_reg;
    logic [32:0] divisor_reg;
    logic        start_reg;
    logic        m_valid_reg, m_kind_reg, m_status_reg;
    logic signed [31:0] m_abs_reg;
    logic [15:0] m_iter_reg;
    logic [30:0] m_err_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    assign dreq.start    = start_reg;
    assign dreq.dividend = dividend_reg;
    assign dreq.divisor  = divisor_reg;

    brs_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_LIMIT) prdata = {16'b0, limit_reg};
        else prdata = {1'b0, tol_reg};
    end

    logic s_fire;
    assign s_fire  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? 32'(-v) : 32'(v);
    endfunction
    function automatic logic [30:0] sat_err(input logic [32:0] m);
        sat_err = (m > 33'(ERR_MAX)) ? ERR_MAX : m[30:0];
    endfunction
    function automatic logic opp(input logic signed [31:0] a, input logic signed [31:0] b);
        opp = (a < 0 && b > 0) || (a > 0 && b < 0);
    endfunction

    logic [32:0] lmag, dmag, quo_sat_in;
    logic signed [32:0] d_xe;
    logic signed [64:0] q_signed, newx_wide;
    assign lmag = {1'b0, mag32(lv_reg)};
    assign d_xe = 33'(xi_reg) - 33'(est_reg);
    assign dmag = d_xe[32] ? 33'(-d_xe) : d_xe;
    assign quo_sat_in = (drsp.quotient > 64'(ERR_MAX)) ? 33'(ERR_MAX)
                                                        : drsp.quotient[32:0];
    assign q_signed  = qneg_reg ? -$signed({1'b0, drsp.quotient})
                                : $signed({1'b0, drsp.quotient});
    assign newx_wide = 65'(up_reg) - q_signed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tol_reg     <= 31'd66;
            limit_reg   <= 16'd100;
            lp_reg <= '0; up_reg <= '0; lv_reg <= '0; uv_reg <= '0;
            est_reg <= '0; pend_reg <= '0; iter_reg <= '0;
            solving_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            start_reg   <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == REG_TOL) tol_reg <= pwdata[30:0];
                else limit_reg <= pwdata[15:0];
            end
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (s_action == ACT_LOAD_LOWER) begin
                            lp_reg <= s_point; lv_reg <= s_function_value;
                            solving_reg <= 1'b0;
                        end else if (s_action == ACT_LOAD_UPPER) begin
                            up_reg <= s_point; uv_reg <= s_function_value;
                            iter_reg <= '0;
                            if (mag32(s_function_value) < lmag[31:0]) begin
                                est_reg <= s_point;
                                err_reg <= sat_err({1'b0, mag32(s_function_value)});
                            end else begin
                                est_reg <= lp_reg;
                                err_reg <= sat_err(lmag);
                            end
                            state_reg <= ST_ADV;
                        end else if (s_action == ACT_VALUE && solving_reg) begin
                            xi_reg <= pend_reg;
                            if (opp(s_function_value, uv_reg)) begin
                                lp_reg <= pend_reg; lv_reg <= s_function_value;
                            end else if (opp(s_function_value, lv_reg)) begin
                                up_reg <= pend_reg; uv_reg <= s_function_value;
                            end
                            if (iter_reg != 16'hFFFF) iter_reg <= iter_reg + 16'd1;
                            state_reg <= ST_ERR_MUL;
                        end
                    end
                end
                ST_ERR_MUL: begin
                    if (est_reg == 0) begin
                        err_reg <= ERR_MAX;
                        est_reg <= xi_reg;
                        state_reg <= ST_ADV;
                    end else begin
                        dividend_reg <= {15'b0, dmag, 16'b0};
                        divisor_reg  <= {1'b0, mag32(est_reg)};
                        start_reg    <= 1'b1;
                        state_reg    <= ST_ERR_WAIT;
                    end
                end
                ST_ERR_WAIT: begin
                    // start is a one-cycle pulse
                    start_reg <= 1'b0;
                    if (drsp.done) begin
                        err_reg <= sat_err(quo_sat_in);
                        est_reg <= xi_reg;
                        state_reg <= ST_ADV;
                    end
                end
                ST_ADV: begin
                    if (err_reg > tol_reg && iter_reg < limit_reg) begin
                        if (lv_reg == uv_reg) begin
                            solving_reg <= 1'b0;
                            m_kind_reg <= KIND_DONE; m_status_reg <= 1'b1;
                            m_abs_reg <= est_reg;
                            state_reg <= ST_OUT;
                        end else begin
                            dx_reg <= 33'(lp_reg) - 33'(up_reg);
                            df_reg <= 33'(lv_reg) - 33'(uv_reg);
                            state_reg <= ST_MUL;
                        end
                    end else begin
                        solving_reg <= 1'b0;
                        m_kind_reg <= KIND_DONE; m_status_reg <= 1'b0;
                        m_abs_reg <= est_reg;
                        state_reg <= ST_OUT;
                    end
                end
                ST_MUL: begin
                    prod_reg <= 65'(uv_reg) * 65'(dx_reg);
                    state_reg <= ST_DIV_START;
                end
                ST_DIV_START: begin
                    dividend_reg <= prod_reg[64] ? 64'(-prod_reg) : prod_reg[63:0];
                    divisor_reg  <= df_reg[32] ? 33'(-df_reg) : df_reg;
                    qneg_reg     <= prod_reg[64] ^ df_reg[32];
                    start_reg    <= 1'b1;
                    state_reg    <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    start_reg <= 1'b0;
                    if (drsp.done) begin
                        if (newx_wide > 65'sh0_7FFF_FFFF) newx_reg <= 32'h7FFF_FFFF;
                        else if (newx_wide < -65'sh0_8000_0000) newx_reg <= 32'h8000_0000;
                        else newx_reg <= newx_wide[31:0];
                        state_reg <= ST_OUT;
                        m_kind_reg <= KIND_REQUEST; m_status_reg <= 1'b0;
                    end
                end
                ST_OUT: begin
                    if (m_kind_reg == KIND_REQUEST) begin
                        pend_reg <= newx_reg;
                        m_abs_reg <= newx_reg;
                        solving_reg <= 1'b1;
                    end
                    m_iter_reg  <= iter_reg;
                    m_err_reg   <= err_reg;
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = m_kind_reg;
    assign m_abscissa      = m_abs_reg;
    assign m_iterations    = m_iter_reg;
    assign m_error_measure = m_err_reg;
    assign m_status        = m_status_reg;

    `ASSERT_IMPLIES(a_ready_idle, aclk, aresetn, s_ready, state_reg == ST_IDLE && !m_valid)
    `ASSERT_IMPLIES(a_req_normal, aclk, aresetn, m_valid && m_kind == KIND_REQUEST, m_status == 1'b0)
    `ASSERT_NEXT(a_div_busy, aclk, aresetn, start_reg, drsp.busy)
endmodule
